>>> src/morse_code_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Morse decoder
// Concurrent checks on i_clk; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_DECODER_UNIT_ASSERT_SVH
`define MORSE_CODE_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define MCD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mcd assertion failed");
// checked at every edge, reset included
`define MCD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("mcd assertion failed");
`else
`define MCD_ASSERT(label, prop)
`define MCD_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> src/mcd_pkg.sv
// ----------------------------------------------------------------------------
// Morse decoder package
// Shared types, register indexes, status codes and the character table.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP_LIMIT = 2'd1;

    localparam logic [23:0] UNIT_TICKS_RST     = 24'd1000;
    localparam logic [7:0]  IDLE_GAP_LIMIT_RST = 8'd20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    localparam logic [2:0] MAX_ELEMENTS = 3'd5;

    localparam logic [6:0] CH_A    = 7'h41;
    localparam logic [6:0] CH_0    = 7'h30;
    localparam logic [6:0] CH_NONE = 7'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // one event handed from the front to the back
    typedef struct packed {
        logic       timeout;
        logic       too_many;
        logic [2:0] count;
        logic [4:0] pattern;
    } t_evt;

    // element count and pattern (element i in bit i, dash = 1) to ASCII
    function automatic logic [6:0] morse_lookup(input logic [2:0] count,
                                                input logic [4:0] pattern);
        logic [6:0] ch;
        ch = CH_NONE;
        case ({count, pattern})
            {3'd2, 5'd2}:  ch = CH_A + 7'd0;
            {3'd4, 5'd1}:  ch = CH_A + 7'd1;
            {3'd4, 5'd5}:  ch = CH_A + 7'd2;
            {3'd3, 5'd1}:  ch = CH_A + 7'd3;
            {3'd1, 5'd0}:  ch = CH_A + 7'd4;
            {3'd4, 5'd4}:  ch = CH_A + 7'd5;
            {3'd3, 5'd3}:  ch = CH_A + 7'd6;
            {3'd4, 5'd0}:  ch = CH_A + 7'd7;
            {3'd2, 5'd0}:  ch = CH_A + 7'd8;
            {3'd4, 5'd14}: ch = CH_A + 7'd9;
            {3'd3, 5'd5}:  ch = CH_A + 7'd10;
            {3'd4, 5'd2}:  ch = CH_A + 7'd11;
            {3'd2, 5'd3}:  ch = CH_A + 7'd12;
            {3'd2, 5'd1}:  ch = CH_A + 7'd13;
            {3'd3, 5'd7}:  ch = CH_A + 7'd14;
            {3'd4, 5'd6}:  ch = CH_A + 7'd15;
            {3'd4, 5'd11}: ch = CH_A + 7'd16;
            {3'd3, 5'd2}:  ch = CH_A + 7'd17;
            {3'd3, 5'd0}:  ch = CH_A + 7'd18;
            {3'd1, 5'd1}:  ch = CH_A + 7'd19;
            {3'd3, 5'd4}:  ch = CH_A + 7'd20;
            {3'd4, 5'd8}:  ch = CH_A + 7'd21;
            {3'd3, 5'd6}:  ch = CH_A + 7'd22;
            {3'd4, 5'd9}:  ch = CH_A + 7'd23;
            {3'd4, 5'd13}: ch = CH_A + 7'd24;
            {3'd4, 5'd3}:  ch = CH_A + 7'd25;
            {3'd5, 5'd31}: ch = CH_0 + 7'd0;
            {3'd5, 5'd30}: ch = CH_0 + 7'd1;
            {3'd5, 5'd28}: ch = CH_0 + 7'd2;
            {3'd5, 5'd24}: ch = CH_0 + 7'd3;
            {3'd5, 5'd16}: ch = CH_0 + 7'd4;
            {3'd5, 5'd0}:  ch = CH_0 + 7'd5;
            {3'd5, 5'd1}:  ch = CH_0 + 7'd6;
            {3'd5, 5'd3}:  ch = CH_0 + 7'd7;
            {3'd5, 5'd7}:  ch = CH_0 + 7'd8;
            {3'd5, 5'd15}: ch = CH_0 + 7'd9;
            default:       ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> src/mcd_front.sv
// ----------------------------------------------------------------------------
// Morse decoder front end
// Times marks and spaces, collects elements and emits character or timeout
// events; also holds the configuration registers.
// ----------------------------------------------------------------------------
module mcd_front #(
    parameter int COUNTER_WIDTH = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_line_level,
    input  logic                          i_cfg_we,
    input  logic [mcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_push,
    output mcd_pkg::t_evt                 o_evt
);
    import mcd_pkg::*;

    localparam int CMP_W = (COUNTER_WIDTH > 25) ? COUNTER_WIDTH : 25;

    logic [23:0]              r_unit;
    logic [7:0]               r_limit;
    logic [COUNTER_WIDTH-1:0] r_space, n_space;
    logic [COUNTER_WIDTH-1:0] r_mark,  n_mark;
    logic                     r_in_char, n_in_char;
    logic [7:0]               r_idle, n_idle;
    logic [2:0]               r_elems, n_elems;
    logic [4:0]               r_pat, n_pat;
    logic                     r_too_many, n_too_many;

    logic [24:0]              twice;
    logic [COUNTER_WIDTH-1:0] sp_base;
    logic [COUNTER_WIDTH-1:0] sp_inc;
    logic                     dash;
    logic                     gap;

    assign twice   = {r_unit, 1'b0};
    assign dash    = CMP_W'(r_mark) >= CMP_W'(twice);
    // first space sample after a mark restarts the space run
    assign sp_base = (r_mark != '0) ? '0 : r_space;
    assign sp_inc  = (&sp_base) ? sp_base : sp_base + 1'b1;
    assign gap     = CMP_W'(sp_inc) > CMP_W'(twice);

    always_comb begin
        n_space    = r_space;
        n_mark     = r_mark;
        n_in_char  = r_in_char;
        n_idle     = r_idle;
        n_elems    = r_elems;
        n_pat      = r_pat;
        n_too_many = r_too_many;
        o_push     = 1'b0;
        o_evt      = '0;
        if (i_accept) begin
            if (i_line_level) begin
                if (!(&r_mark)) begin
                    n_mark = r_mark + 1'b1;
                end
                n_space = '0;
            end else begin
                if (r_mark != '0) begin
                    if (r_elems < MAX_ELEMENTS) begin
                        if (dash) begin
                            n_pat = r_pat | (5'd1 << r_elems);
                        end
                        n_elems = r_elems + 3'd1;
                    end else begin
                        n_too_many = 1'b1;
                    end
                    n_in_char = 1'b1;
                    n_mark    = '0;
                end
                n_space = sp_inc;
                if (gap) begin
                    n_space = '0;
                    if (n_in_char) begin
                        o_push       = 1'b1;
                        o_evt.too_many = n_too_many;
                        o_evt.count  = n_elems;
                        o_evt.pattern = n_pat;
                        n_in_char  = 1'b0;
                        n_elems    = '0;
                        n_pat      = '0;
                        n_too_many = 1'b0;
                        n_idle     = '0;
                    end else if (r_idle >= r_limit) begin
                        o_push        = 1'b1;
                        o_evt.timeout = 1'b1;
                        n_idle        = '0;
                    end else begin
                        n_idle = r_idle + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit     <= UNIT_TICKS_RST;
            r_limit    <= IDLE_GAP_LIMIT_RST;
            r_space    <= '0;
            r_mark     <= '0;
            r_in_char  <= 1'b0;
            r_idle     <= '0;
            r_elems    <= '0;
            r_pat      <= '0;
            r_too_many <= 1'b0;
        end else begin
            r_space    <= n_space;
            r_mark     <= n_mark;
            r_in_char  <= n_in_char;
            r_idle     <= n_idle;
            r_elems    <= n_elems;
            r_pat      <= n_pat;
            r_too_many <= n_too_many;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_UNIT_TICKS:     r_unit  <= i_cfg_data;
                    REG_IDLE_GAP_LIMIT: r_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> src/mcd_queue.sv
// ----------------------------------------------------------------------------
// Morse decoder event queue
// Small FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "morse_code_decoder_unit_assert.svh"

module mcd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcd_pkg::t_evt i_evt,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mcd_pkg::t_evt o_evt
);
    import mcd_pkg::*;

    t_evt                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `MCD_ASSERT(a_cnt_bound, r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    `MCD_ASSERT(a_no_push_full, i_push |-> !o_full)
    `MCD_ASSERT(a_no_pop_empty, i_pop |-> o_valid)

endmodule

>>> src/mcd_back.sv
// ----------------------------------------------------------------------------
// Morse decoder output stage
// Decodes queued events through the character table into the output register.
// ----------------------------------------------------------------------------
`include "morse_code_decoder_unit_assert.svh"

module mcd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mcd_pkg::t_evt i_q_evt,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [6:0]    o_char_code,
    output logic [1:0]    o_status,
    output logic [2:0]    o_element_count,
    output logic [4:0]    o_element_pattern
);
    import mcd_pkg::*;

    logic       r_valid;
    logic [6:0] r_code;
    logic [1:0] r_status;
    logic [2:0] r_count;
    logic [4:0] r_pat;

    logic       load;
    logic [6:0] lut_code;
    logic [6:0] n_code;
    logic [1:0] n_status;

    assign load     = !r_valid || !i_out_stall;
    assign o_pop    = i_q_valid && load;
    assign lut_code = morse_lookup(i_q_evt.count, i_q_evt.pattern);

    always_comb begin
        n_code   = CH_NONE;
        n_status = ST_OK;
        if (i_q_evt.timeout) begin
            n_status = ST_TIMEOUT;
        end else if (i_q_evt.too_many) begin
            n_status = ST_TOO_MANY;
        end else if (lut_code == CH_NONE) begin
            n_status = ST_UNKNOWN;
        end else begin
            n_code = lut_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
        end
    end

    // payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code   <= n_code;
            r_status <= n_status;
            r_count  <= i_q_evt.count;
            r_pat    <= i_q_evt.pattern;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_char_code       = r_code;
    assign o_status          = r_status;
    assign o_element_count   = r_count;
    assign o_element_pattern = r_pat;

    `MCD_ASSERT(a_pop_fills, o_pop |=> r_valid)
    `MCD_ASSERT(a_timeout_blank,
        (r_valid && r_status == ST_TIMEOUT) |-> (r_code == CH_NONE && r_count == 3'd0))
    `MCD_ASSERT(a_code_ok, (r_valid && r_code != CH_NONE) |-> r_status == ST_OK)

endmodule

>>> src/morse_code_decoder_unit.sv
// ----------------------------------------------------------------------------
// Morse code decoder unit
// Times line samples into dots, dashes and gaps and reports decoded letters,
// digits, unknown patterns, overlong characters and idle timeouts.
// ----------------------------------------------------------------------------
// Throughput: one line sample per cycle while the event queue is not full;
//   the front end finishes each sample in the cycle it is accepted.
// The closing sample's event is written into the event queue at the edge that
//   takes it, then loaded into the output register when the output stage loads.
// Input stalls only when the four-entry event queue is full. Synchronous
//   active-low reset restores unit 1000, idle limit 20, clears control state.
module morse_code_decoder_unit #(
    parameter int COUNTER_WIDTH = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_line_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [6:0]                    o_char_code,
    output logic [1:0]                    o_status,
    output logic [2:0]                    o_element_count,
    output logic [4:0]                    o_element_pattern,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import mcd_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_evt f_evt;
    t_evt q_evt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    mcd_front #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_line_level (i_line_level),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_evt        (f_evt)
    );

    mcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (f_evt),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_evt   (q_evt)
    );

    mcd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_evt           (q_evt),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_char_code       (o_char_code),
        .o_status          (o_status),
        .o_element_count   (o_element_count),
        .o_element_pattern (o_element_pattern)
    );

endmodule

>>> tb/morse_code_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// Morse code decoder unit testbench
// Feeds line samples: a table of hand-built characters first, then random
// well-formed characters mixed with noise and broken spacing, over several
// unit and idle-limit settings. Each result is compared field by field with
// the output of a cycle-free decoder model kept inside this bench.
// ----------------------------------------------------------------------------
module morse_code_decoder_unit_tb;
    import mcd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 8;
    localparam int DIR_N        = 16;

    // indexes the block does not decode; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [25:0] CNT_FULL = '1;

    typedef struct packed {
        logic [6:0] ch;
        logic [1:0] st;
        logic [2:0] cnt;
        logic [4:0] pat;
    } t_char_result;

    typedef struct packed {
        bit           typed;
        t_char_result res;
    } t_sample_tag;

    // one hand-built character: element i is a dash when dashes[i] is set
    typedef struct packed {
        logic [3:0]   n_el;
        logic [7:0]   dashes;
        logic [7:0]   dash_len;
        logic [7:0]   gap;
        bit           typed;
        t_char_result res;
    } t_dir_row;

    localparam t_char_result NO_RES = '0;
    localparam t_sample_tag  NO_TAG = '0;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_stall;
    logic                 i_line_level      = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall       = 1'b0;
    logic [6:0]           o_char_code;
    logic [1:0]           o_status;
    logic [2:0]           o_element_count;
    logic [4:0]           o_element_pattern;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index       = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data        = '0;

    morse_code_decoder_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_line_level      (i_line_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_char_code       (o_char_code),
        .o_status          (o_status),
        .o_element_count   (o_element_count),
        .o_element_pattern (o_element_pattern),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    string morse_tab [0:35] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----."
    };

    logic [23:0] unit_ticks;
    logic [7:0]  idle_limit;
    logic [25:0] space_cnt;
    logic [25:0] mark_cnt;
    bit          char_open;
    logic [7:0]  idle_gaps;
    logic [2:0]  elem_cnt;
    logic [4:0]  elem_bits;
    bit          overflow;

    function automatic void model_reset();
        unit_ticks = UNIT_TICKS_RST;
        idle_limit = IDLE_GAP_LIMIT_RST;
        space_cnt  = '0;
        mark_cnt   = '0;
        idle_gaps  = '0;
        char_open  = 1'b0;
        elem_cnt   = '0;
        elem_bits  = '0;
        overflow   = 1'b0;
    endfunction

    function automatic logic [6:0] char_of(input logic [2:0] count,
                                           input logic [4:0] pattern);
        string      s;
        logic [4:0] pat;
        int         n;
        for (int i = 0; i < 36; i++) begin
            s   = morse_tab[i];
            n   = s.len();
            pat = '0;
            for (int k = 0; k < n; k++)
                if (s[k] == "-")
                    pat[k] = 1'b1;
            if (n == int'(count) && pat == pattern)
                return (i < 26) ? CH_A + 7'(i) : CH_0 + 7'(i - 26);
        end
        return CH_NONE;
    endfunction

    // advance the model by one line sample; returns 1 when a result comes out
    function automatic bit decode_sample(input logic level, output t_char_result r);
        logic [25:0] twice_u;
        r       = NO_RES;
        twice_u = {1'b0, unit_ticks, 1'b0};
        if (level) begin
            if (mark_cnt != CNT_FULL)
                mark_cnt = mark_cnt + 26'd1;
            space_cnt = '0;
            return 1'b0;
        end
        if (mark_cnt != '0) begin
            if (elem_cnt < MAX_ELEMENTS) begin
                if (mark_cnt >= twice_u)
                    elem_bits[elem_cnt] = 1'b1;
                elem_cnt = elem_cnt + 3'd1;
            end else begin
                overflow = 1'b1;
            end
            char_open = 1'b1;
            mark_cnt  = '0;
            space_cnt = '0;
        end
        if (space_cnt != CNT_FULL)
            space_cnt = space_cnt + 26'd1;
        if (space_cnt <= twice_u)
            return 1'b0;
        space_cnt = '0;
        if (char_open) begin
            r.cnt = elem_cnt;
            r.pat = elem_bits;
            if (overflow) begin
                r.st = ST_TOO_MANY;
            end else begin
                r.ch = char_of(elem_cnt, elem_bits);
                r.st = (r.ch != CH_NONE) ? ST_OK : ST_UNKNOWN;
            end
            char_open = 1'b0;
            elem_cnt  = '0;
            elem_bits = '0;
            overflow  = 1'b0;
            idle_gaps = '0;
            return 1'b1;
        end
        if (idle_gaps >= idle_limit) begin
            idle_gaps = '0;
            r.st      = ST_TIMEOUT;
            return 1'b1;
        end
        idle_gaps = idle_gaps + 8'd1;
        return 1'b0;
    endfunction

    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
        if (idx == REG_UNIT_TICKS)
            unit_ticks = data;
        else if (idx == REG_IDLE_GAP_LIMIT)
            idle_limit = data[7:0];
    endfunction

    // ------------------------------------------------------------------
    // sample feed, result sink and checking
    // ------------------------------------------------------------------
    logic         line_samples [$];
    t_sample_tag  sample_tags  [$];
    t_char_result pending_chars [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_cnt   = 0;
    int cycle_cnt      = 0;
    int queued         = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // hold valid and level until the item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_line_level <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                line_samples.delete(0);
            if (!i_in_valid || !o_in_stall) begin
                if (line_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid   <= 1'b1;
                    i_line_level <= line_samples[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_cnt < 40)
            $display("mismatch: %s expected %0d got %0d (cycle %0d)",
                     what, want, got, cycle_cnt);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_char_result want;
        t_char_result got_r;
        t_sample_tag  tag;
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch("result with none pending, status", -1, o_status);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_char_code != want.ch)
                        report_mismatch("char_code", want.ch, o_char_code);
                    if (o_status != want.st)
                        report_mismatch("status", want.st, o_status);
                    if (o_element_count != want.cnt)
                        report_mismatch("element_count", want.cnt, o_element_count);
                    if (o_element_pattern != want.pat)
                        report_mismatch("element_pattern", want.pat, o_element_pattern);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                tag = sample_tags.pop_front();
                if (decode_sample(i_line_level, got_r) || tag.typed)
                    pending_chars.push_back(tag.typed ? tag.res : got_r);
            end
            if (i_cfg_valid && o_cfg_ready)
                model_write(i_cfg_index, i_cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // unit 1: dot is one tick, dash two or more, three spaces close a character
    t_dir_row dir_rows [DIR_N] = '{
        '{4'd0, 8'h00, 8'd2,  8'd9,  1'b0, NO_RES},                     // flush
        '{4'd1, 8'h00, 8'd2,  8'd3,  1'b1, '{7'h45, ST_OK, 3'd1, 5'd0}},  // E
        '{4'd5, 8'h1F, 8'd2,  8'd3,  1'b1, '{CH_0, ST_OK, 3'd5, 5'd31}},  // 0
        '{4'd5, 8'h00, 8'd2,  8'd3,  1'b1, '{7'h35, ST_OK, 3'd5, 5'd0}},  // 5
        '{4'd4, 8'h0C, 8'd2,  8'd3,  1'b1, '{CH_NONE, ST_UNKNOWN, 3'd4, 5'd12}},
        '{4'd6, 8'h00, 8'd2,  8'd3,  1'b1, '{CH_NONE, ST_TOO_MANY, 3'd5, 5'd0}},
        '{4'd7, 8'h7F, 8'd2,  8'd3,  1'b1, '{CH_NONE, ST_TOO_MANY, 3'd5, 5'd31}},
        '{4'd3, 8'h04, 8'd2,  8'd3,  1'b1, '{7'h55, ST_OK, 3'd3, 5'd4}},  // U
        '{4'd3, 8'h03, 8'd2,  8'd3,  1'b1, '{7'h47, ST_OK, 3'd3, 5'd3}},  // G
        '{4'd2, 8'h02, 8'd2,  8'd3,  1'b1, '{CH_A, ST_OK, 3'd2, 5'd2}},   // A
        '{4'd0, 8'h00, 8'd2,  8'd6,  1'b1, '{CH_NONE, ST_TIMEOUT, 3'd0, 5'd0}},
        '{4'd1, 8'h01, 8'd40, 8'd3,  1'b1, '{7'h54, ST_OK, 3'd1, 5'd1}},  // T
        '{4'd5, 8'h03, 8'd2,  8'd3,  1'b0, NO_RES},                     // 7
        '{4'd4, 8'h06, 8'd3,  8'd10, 1'b0, NO_RES},                     // P, idles
        '{4'd2, 8'h01, 8'd2,  8'd2,  1'b0, NO_RES},                     // gap too short
        '{4'd1, 8'h00, 8'd2,  8'd3,  1'b0, NO_RES}                      // closes D
    };

    task automatic push_sample(input logic lvl, input t_sample_tag tag);
        line_samples.push_back(lvl);
        sample_tags.push_back(tag);
        queued++;
    endtask

    task automatic emit(input logic lvl, input int n);
        for (int k = 0; k < n; k++)
            push_sample(lvl, NO_TAG);
    endtask

    task automatic play_row(input t_dir_row row);
        t_sample_tag tag;
        tag.typed = row.typed;
        tag.res   = row.res;
        for (int e = 0; e < int'(row.n_el); e++) begin
            emit(1'b1, row.dashes[e] ? int'(row.dash_len) : 1);
            if (e != int'(row.n_el) - 1)
                emit(1'b0, 2);
        end
        for (int g = 0; g < int'(row.gap); g++)
            push_sample(1'b0, (g == int'(row.gap) - 1) ? tag : NO_TAG);
    endtask

    task automatic push_random_char(input int u);
        int n_el;
        int len;
        bit dash;
        n_el = ($urandom_range(99) < 10) ? $urandom_range(7, 6) : $urandom_range(5, 1);
        for (int e = 0; e < n_el; e++) begin
            dash = $urandom_range(1);
            len  = dash ? $urandom_range(2 * u + 2, 2 * u) : $urandom_range(2 * u - 1, 1);
            emit(1'b1, len);
            // now and then stretch the element space past the gap threshold
            if (e != n_el - 1)
                emit(1'b0, ($urandom_range(99) < 5) ? $urandom_range(2 * u + 2, 1)
                                                    : $urandom_range(2 * u, 1));
        end
        emit(1'b0, ($urandom_range(99) < 15) ? $urandom_range(12 * u + 6, 2 * u + 1)
                                             : $urandom_range(2 * u + 3, 2 * u + 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int u, input int lim);
        write_reg(REG_UNIT_TICKS, CFG_DAT_W'(u));
        write_reg(REG_IDLE_GAP_LIMIT, CFG_DAT_W'(lim));
        @(negedge i_clk);
    endtask

    // wait until every item is taken and every result is in, then let the
    // output pipeline run dry
    task automatic settle();
        do @(negedge i_clk);
        while (line_samples.size() != 0 || i_in_valid || pending_chars.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic run_phase(input int u, input int lim, input int idle,
                             input int stall, input int n, input bit noise);
        configure(u, lim);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        queued         = 0;
        while (queued < n) begin
            if (noise || $urandom_range(99) < 12) begin
                for (int k = $urandom_range(10, 1); k > 0; k--)
                    push_sample($urandom_range(1), NO_TAG);
            end else begin
                push_random_char(u);
            end
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // a few samples at the reset settings: far too short to give a result
        for (int k = 0; k < 8; k++)
            push_sample($urandom_range(1), NO_TAG);
        settle();

        configure(1, 1);
        for (int i = 0; i < DIR_N; i++)
            play_row(dir_rows[i]);
        settle();

        run_phase(1, 0,   0,  0,  230, 1'b0);
        run_phase(2, 3,   77, 0,  200, 1'b0);
        run_phase(3, 255, 0,  77, 200, 1'b0);
        run_phase(1, 2,   34, 34, 200, 1'b0);
        // zero unit: every mark a dash, every space sample a gap
        run_phase(0, 2,   0,  0,  40,  1'b1);
        // widest unit: all marks are dots and no gap can fire here
        run_phase(24'hFFFFFF, 0, 34, 34, 40, 1'b1);
        write_reg(REG_SPARE_2, CFG_DAT_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DAT_W'($urandom));
        run_phase(2, $urandom_range(5, 0), 0, 0, 150, 1'b0);

        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/mcd_pkg.sv
src/mcd_front.sv
src/mcd_queue.sv
src/mcd_back.sv
src/morse_code_decoder_unit.sv
tb/morse_code_decoder_unit_tb.sv
